// ----- hw/rtl/mes_pkg.sv -----
// Shared types and constants of the Moran event scheduler.
package mes_pkg;

  localparam int TIME_W       = 48;
  localparam int NODE_FIELD_W = 7;
  localparam int NODE_CODES   = 128;
  localparam int HIT_W        = 16;
  localparam int ONES_W       = 8;
  localparam int OP_W         = 2;
  localparam int STATUS_W     = 2;
  localparam int IN_DATA_W    = 56;
  localparam int OUT_DATA_W   = 80;

  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD     = 2'd1;
  localparam logic [OP_W-1:0] OP_ACTIVATE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  localparam logic [HIT_W-1:0] HIT_MAX = 16'hFFFF;
  localparam logic [TIME_W-1:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic clear;
    logic insert;
    logic pop;
  } chain_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_POP,
    ST_ACT,
    ST_OUT
  } state_t;

endpackage

// ----- hw/rtl/mes_cell.sv -----
// One cell of the sorted schedule chain, holding a single time and node entry.
module mes_cell #(
  parameter int IDX_W = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mes_pkg::chain_ctrl_t       ctrl,
  input  logic [mes_pkg::TIME_W-1:0] new_time,
  input  logic [IDX_W-1:0]           new_node,
  input  logic                       prev_keep,
  input  logic                       prev_valid,
  input  logic [mes_pkg::TIME_W-1:0] prev_time,
  input  logic [IDX_W-1:0]           prev_node,
  input  logic                       next_valid,
  input  logic [mes_pkg::TIME_W-1:0] next_time,
  input  logic [IDX_W-1:0]           next_node,
  output logic                       ent_valid,
  output logic [mes_pkg::TIME_W-1:0] ent_time,
  output logic [IDX_W-1:0]           ent_node,
  output logic                       keep
);

  // An entry stays in place on insertion only if it is strictly earlier.
  assign keep = ent_valid && (ent_time < new_time);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (ctrl.clear) begin
      ent_valid <= 1'b0;
    end else if (ctrl.pop) begin
      ent_valid <= next_valid;
    end else if (ctrl.insert && !keep) begin
      ent_valid <= prev_keep ? 1'b1 : prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      ent_time <= next_time;
      ent_node <= next_node;
    end else if (ctrl.insert && !keep) begin
      if (prev_keep) begin
        ent_time <= new_time;
        ent_node <= new_node;
      end else begin
        ent_time <= prev_time;
        ent_node <= prev_node;
      end
    end
  end

endmodule

// ----- hw/rtl/mes_chain.sv -----
// Row of schedule cells forming a time-sorted shift-register queue.
module mes_chain #(
  parameter int NODES = 128,
  parameter int IDX_W = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mes_pkg::chain_ctrl_t       ctrl,
  input  logic [mes_pkg::TIME_W-1:0] new_time,
  input  logic [IDX_W-1:0]           new_node,
  output logic [mes_pkg::TIME_W-1:0] head_time,
  output logic [IDX_W-1:0]           head_node
);

  logic                       cv [NODES];
  logic [mes_pkg::TIME_W-1:0] ct [NODES];
  logic [IDX_W-1:0]           cn [NODES];
  logic                       ck [NODES];

  assign head_time = ct[0];
  assign head_node = cn[0];

  for (genvar gi = 0; gi < NODES; gi++) begin : g_cell
    logic                       p_keep;
    logic                       p_valid;
    logic [mes_pkg::TIME_W-1:0] p_time;
    logic [IDX_W-1:0]           p_node;
    logic                       n_valid;
    logic [mes_pkg::TIME_W-1:0] n_time;
    logic [IDX_W-1:0]           n_node;

    if (gi == 0) begin : g_first
      assign p_keep  = 1'b1;
      assign p_valid = 1'b0;
      assign p_time  = '0;
      assign p_node  = '0;
    end else begin : g_mid
      assign p_keep  = ck[gi-1];
      assign p_valid = cv[gi-1];
      assign p_time  = ct[gi-1];
      assign p_node  = cn[gi-1];
    end

    if (gi == NODES - 1) begin : g_last
      assign n_valid = 1'b0;
      assign n_time  = '0;
      assign n_node  = '0;
    end else begin : g_inner
      assign n_valid = cv[gi+1];
      assign n_time  = ct[gi+1];
      assign n_node  = cn[gi+1];
    end

    mes_cell #(
      .IDX_W(IDX_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .new_time  (new_time),
      .new_node  (new_node),
      .prev_keep (p_keep),
      .prev_valid(p_valid),
      .prev_time (p_time),
      .prev_node (p_node),
      .next_valid(n_valid),
      .next_time (n_time),
      .next_node (n_node),
      .ent_valid (cv[gi]),
      .ent_time  (ct[gi]),
      .ent_node  (cn[gi]),
      .keep      (ck[gi])
    );
  end

endmodule

// ----- hw/rtl/moran_event_scheduler.sv -----
// Top level of the Moran event scheduler: sequencer, opinion and hit stores, schedule chain.
//
//  Channel | Direction | Handshake         | Contents
//  s       | in        | s_tvalid/s_tready | tuser op, tdata node, opinion, time
//  m       | out       | m_tvalid/m_tready | tuser status, tdata result fields
//
// A clear, an unused code or a rejected item goes straight to ST_OUT; a load passes ST_LOAD
// first, an activate ST_POP and ST_ACT, for the registered store reads and the chain shift.
// Only one item is in work at a time; a finished result waits in the output register.
// Reset is synchronous and clears the chain, the counts and the store valid bits.
// A stalled output holds the sequencer in its final state until the transfer completes.
module moran_event_scheduler #(
  parameter int NODES = 128
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [1:0]   s_tuser,  // op
  input  logic [55:0]  s_tdata,  // node_index[6:0], node_opinion[7], time_value[55:8]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [1:0]   m_tuser,  // status
  output logic [79:0]  m_tdata   // activated_node, activation_time, copied_opinion,
                                 // ones_count, target_hits
);

  localparam int IDX_W = $clog2(NODES);
  localparam int CNT_W = $clog2(NODES + 1);

  mes_pkg::state_t state;
  mes_pkg::state_t state_next;
  mes_pkg::chain_ctrl_t ctrl;

  logic accept;
  logic slot_free;

  logic [mes_pkg::NODE_FIELD_W-1:0] in_node;
  logic                             in_opin;
  logic [mes_pkg::TIME_W-1:0]       in_time;
  logic [IDX_W-1:0]                 in_idx;
  logic [IDX_W-1:0]                 mod_tab [mes_pkg::NODE_CODES];

  logic [IDX_W-1:0]           idx_r;
  logic                       opin_r;
  logic [mes_pkg::TIME_W-1:0] tv_r;
  logic [IDX_W-1:0]           src_r;
  logic [mes_pkg::TIME_W-1:0] t_r;
  logic [mes_pkg::TIME_W-1:0] nt_r;
  logic [mes_pkg::TIME_W:0]   sum;

  logic [CNT_W-1:0]          loaded_count;
  logic [mes_pkg::ONES_W-1:0] ones_total;
  logic [mes_pkg::ONES_W-1:0] ones_next;
  logic [NODES-1:0]          opin_val;
  logic [NODES-1:0]          hit_val;

  logic                      opin_mem [NODES];
  logic [mes_pkg::HIT_W-1:0] hit_mem  [NODES];
  logic [IDX_W-1:0]          rd_b;
  logic                      opa_q;
  logic                      opb_q;
  logic [mes_pkg::HIT_W-1:0] hit_q;

  logic                      v_src;
  logic                      v_old;
  logic [mes_pkg::HIT_W-1:0] hit_old;
  logic [mes_pkg::HIT_W-1:0] hit_new;

  logic [mes_pkg::TIME_W-1:0] head_time;
  logic [IDX_W-1:0]           head_node;
  logic [mes_pkg::TIME_W-1:0] new_time;
  logic [IDX_W-1:0]           new_node;

  logic [mes_pkg::STATUS_W-1:0]     res_status;
  logic [mes_pkg::NODE_FIELD_W-1:0] res_node;
  logic [mes_pkg::TIME_W-1:0]       res_time;
  logic                             res_copied;
  logic [mes_pkg::ONES_W-1:0]       res_ones;
  logic [mes_pkg::HIT_W-1:0]        res_hits;

  assign in_node = s_tdata[6:0];
  assign in_opin = s_tdata[7];
  assign in_time = s_tdata[55:8];

  for (genvar gi = 0; gi < mes_pkg::NODE_CODES; gi++) begin : g_mod
    assign mod_tab[gi] = IDX_W'(gi % NODES);
  end
  assign in_idx = mod_tab[in_node];

  assign s_tready  = (state == mes_pkg::ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;

  assign sum      = {1'b0, head_time} + {1'b0, tv_r};
  assign v_src    = opin_val[src_r] & opa_q;
  assign v_old    = opin_val[idx_r] & opb_q;
  assign hit_old  = hit_val[idx_r] ? hit_q : '0;
  assign hit_new  = (hit_old == mes_pkg::HIT_MAX) ? hit_old : hit_old + 1'b1;
  assign new_time = (state == mes_pkg::ST_ACT) ? nt_r : tv_r;
  assign new_node = (state == mes_pkg::ST_ACT) ? src_r : idx_r;
  assign rd_b     = (state == mes_pkg::ST_IDLE) ? in_idx : idx_r;

  always_comb begin
    state_next  = state;
    ctrl        = '0;
    ones_next   = ones_total;
    case (state)
      mes_pkg::ST_IDLE: begin
        if (accept) begin
          case (s_tuser)
            mes_pkg::OP_CLEAR: begin
              ctrl.clear = 1'b1;
              state_next = mes_pkg::ST_OUT;
            end
            mes_pkg::OP_LOAD: begin
              state_next = (loaded_count == CNT_W'(NODES)) ? mes_pkg::ST_OUT
                                                            : mes_pkg::ST_LOAD;
            end
            mes_pkg::OP_ACTIVATE: begin
              state_next = (loaded_count == '0) ? mes_pkg::ST_OUT : mes_pkg::ST_POP;
            end
            default: begin
              state_next = mes_pkg::ST_OUT;
            end
          endcase
        end
      end
      mes_pkg::ST_LOAD: begin
        ctrl.insert = 1'b1;
        ones_next   = ones_total - mes_pkg::ONES_W'(v_old) + mes_pkg::ONES_W'(opin_r);
        state_next  = mes_pkg::ST_OUT;
      end
      mes_pkg::ST_POP: begin
        ctrl.pop   = 1'b1;
        state_next = mes_pkg::ST_ACT;
      end
      mes_pkg::ST_ACT: begin
        ctrl.insert = 1'b1;
        ones_next   = ones_total - mes_pkg::ONES_W'(v_old) + mes_pkg::ONES_W'(v_src);
        state_next  = mes_pkg::ST_OUT;
      end
      mes_pkg::ST_OUT: begin
        if (slot_free) begin
          state_next = mes_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mes_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mes_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
      ones_total   <= '0;
      opin_val     <= '0;
      hit_val      <= '0;
    end else if (ctrl.clear) begin
      loaded_count <= '0;
      ones_total   <= '0;
      opin_val     <= '0;
      hit_val      <= '0;
    end else if (state == mes_pkg::ST_LOAD) begin
      loaded_count    <= loaded_count + 1'b1;
      ones_total      <= ones_next;
      opin_val[idx_r] <= 1'b1;
    end else if (state == mes_pkg::ST_ACT) begin
      ones_total      <= ones_next;
      opin_val[idx_r] <= 1'b1;
      hit_val[idx_r]  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    opa_q <= opin_mem[head_node];
    opb_q <= opin_mem[rd_b];
    hit_q <= hit_mem[rd_b];
    if (state == mes_pkg::ST_LOAD) begin
      opin_mem[idx_r] <= opin_r;
    end else if (state == mes_pkg::ST_ACT) begin
      opin_mem[idx_r] <= v_src;
      hit_mem[idx_r]  <= hit_new;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r      <= in_idx;
      opin_r     <= in_opin;
      tv_r       <= in_time;
      res_node   <= '0;
      res_time   <= '0;
      res_copied <= 1'b0;
      res_hits   <= '0;
      res_ones   <= (s_tuser == mes_pkg::OP_CLEAR) ? '0 : ones_total;
      if (s_tuser == mes_pkg::OP_LOAD && loaded_count == CNT_W'(NODES)) begin
        res_status <= mes_pkg::STATUS_FULL;
      end else if (s_tuser == mes_pkg::OP_ACTIVATE && loaded_count == '0) begin
        res_status <= mes_pkg::STATUS_EMPTY;
      end else begin
        res_status <= mes_pkg::STATUS_OK;
      end
    end
    if (state == mes_pkg::ST_POP) begin
      src_r <= head_node;
      t_r   <= head_time;
      nt_r  <= sum[mes_pkg::TIME_W] ? mes_pkg::TIME_MAX : sum[mes_pkg::TIME_W-1:0];
    end
    if (state == mes_pkg::ST_LOAD) begin
      res_ones <= ones_next;
    end
    if (state == mes_pkg::ST_ACT) begin
      res_ones   <= ones_next;
      res_node   <= mes_pkg::NODE_FIELD_W'(src_r);
      res_time   <= t_r;
      res_copied <= v_src;
      res_hits   <= hit_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == mes_pkg::ST_OUT && slot_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mes_pkg::ST_OUT && slot_free) begin
      m_tuser <= res_status;
      m_tdata <= {res_hits, res_ones, res_copied, res_time, res_node};
    end
  end

  mes_chain #(
    .NODES(NODES),
    .IDX_W(IDX_W)
  ) u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .new_time (new_time),
    .new_node (new_node),
    .head_time(head_time),
    .head_node(head_node)
  );

endmodule
